// ===== hw/rtl/itv_pkg.sv =====
// Shared types and constants for the interval track assigner.
// No dependencies; imported by every module of the block but itv_store.
package itv_pkg;

  // Fixed field widths of the transaction payloads
  localparam int unsigned ID_W      = 16;
  localparam int unsigned QPOS_W    = 24;
  localparam int unsigned QTRK_W    = 5;
  localparam int unsigned TRK_OUT_W = 5;
  localparam int unsigned IDX_OUT_W = 8;
  localparam int unsigned CNT_OUT_W = 6;
  localparam int unsigned LEN_W     = 24;

  // Register port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic        REG_SEQ_LEN = 1'b0;  // word index of sequence_length

  typedef enum logic [1:0] {
    ACT_ADD   = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_NO_TRACK = 2'd2
  } status_e;

endpackage

// ===== hw/rtl/itv_store.sv =====
// Interval table: one write port, one registered read port.
// Depends on nothing but its parameters.
module itv_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 71
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // Write the appended entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Register the read word
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/itv_cmp.sv =====
// Shared compare unit: overlap test for adds, track and coverage test for queries.
// Depends on itv_pkg for the fixed query field widths.
module itv_cmp #(
  parameter int unsigned POS_BITS = 25,
  parameter int unsigned TW       = 5
) (
  input  logic                                is_add_i,
  input  logic signed [POS_BITS-1:0]          ent_start_i,
  input  logic signed [POS_BITS-1:0]          ent_end_i,
  input  logic        [TW-1:0]                ent_trk_i,
  input  logic signed [POS_BITS-1:0]          new_start_i,
  input  logic signed [POS_BITS-1:0]          new_end_i,
  input  logic        [itv_pkg::QPOS_W-1:0]   qpos_i,
  input  logic        [itv_pkg::QTRK_W-1:0]   qtrk_i,
  input  logic        [itv_pkg::LEN_W-1:0]    seq_len_i,
  output logic                                match_o
);
  import itv_pkg::*;

  // Wide enough for the signed positions, the unsigned query and end minus length
  localparam int unsigned W  = ((POS_BITS > QPOS_W + 1) ? POS_BITS : QPOS_W + 1) + 1;
  localparam int unsigned QW = (TW > QTRK_W) ? TW : QTRK_W;

  logic signed [W-1:0] s, e, p, len, e_wrap;
  logic overlap, trk_eq, inside_span, covers;

  assign s      = W'(ent_start_i);
  assign e      = W'(ent_end_i);
  assign p      = signed'(W'(qpos_i));
  assign len    = signed'(W'(seq_len_i));
  assign e_wrap = e - len;

  // Two intervals overlap when each starts no later than the other ends
  assign overlap = (ent_start_i <= new_end_i) && (ent_end_i >= new_start_i);

  assign trk_eq = (QW'(ent_trk_i) == QW'(qtrk_i));

  // Coverage with wrap for reversed intervals and intervals past the sequence end
  assign inside_span = (p >= s) && (p <= e);
  always_comb begin
    if (inside_span) begin
      covers = 1'b1;
    end else if (e < s) begin
      covers = (p >= s) || (p <= e);
    end else if (e >= len) begin
      covers = (p >= s) || (p <= e_wrap);
    end else begin
      covers = 1'b0;
    end
  end

  assign match_o = is_add_i ? overlap : (trk_eq && covers);

endmodule

// ===== hw/rtl/interval_track_assigner.sv =====
// Interval track assigner: sequencer, table and shared compare unit.
// Depends on itv_pkg, itv_store and itv_cmp.
//
// Each transaction on the input channel yields exactly one result transaction.
// An add or a query walks the stored intervals one per cycle through a single
// compare unit fed by the table's one read port; an add then picks the lowest
// free track and appends the entry. Clear, unknown actions and adds to a full
// table go straight to the result. The input is ready only between
// transactions, while a finished result may still wait in the output register.
// Reset empties the table at once; there is no clearing pass.
// sequence_length sits at byte address 0 of the register port (reset 1).
module interval_track_assigner #(
  parameter int unsigned MAX_ENTRIES = 256,
  parameter int unsigned MAX_TRACKS  = 32,
  parameter int unsigned POS_BITS    = 25
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [itv_pkg::APB_AW-1:0]           paddr,
  input  logic [itv_pkg::APB_DW-1:0]           pwdata,
  output logic [itv_pkg::APB_DW-1:0]           prdata,
  output logic                                 pready,
  // input channel
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [1:0]                           action_i,
  input  logic [itv_pkg::ID_W-1:0]             entry_id_i,
  input  logic signed [POS_BITS-1:0]           start_pos_i,
  input  logic signed [POS_BITS-1:0]           end_pos_i,
  input  logic [itv_pkg::QPOS_W-1:0]           query_pos_i,
  input  logic [itv_pkg::QTRK_W-1:0]           query_track_i,
  // output channel
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [1:0]                           status_o,
  output logic                                 hit_o,
  output logic [itv_pkg::TRK_OUT_W-1:0]        track_o,
  output logic [itv_pkg::IDX_OUT_W-1:0]        entry_index_o,
  output logic [itv_pkg::ID_W-1:0]             found_id_o,
  output logic [itv_pkg::CNT_OUT_W-1:0]        track_count_o
);
  import itv_pkg::*;

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned TW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TRACKS + 1);
  localparam int unsigned DW = ID_W + 2 * POS_BITS + TW;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_FIND = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // latched transaction
  action_e                    action_q;
  logic [ID_W-1:0]            id_q;
  logic signed [POS_BITS-1:0] start_q, end_q;
  logic [QPOS_W-1:0]          qpos_q;
  logic [QTRK_W-1:0]          qtrk_q;

  // configuration and table bookkeeping
  logic [LEN_W-1:0] seq_len_q;
  logic [IW:0]      count_q, count_d;
  logic [CW-1:0]    used_q, used_d;

  // scan control
  logic [IW:0]           rd_idx_q, rd_idx_d;
  logic                  pend_q, pend_d;
  logic [IW-1:0]         cmp_idx_q, cmp_idx_d;
  logic [MAX_TRACKS-1:0] busy_q, busy_d;
  logic                  found_q, found_d;
  logic [IW-1:0]         found_idx_q, found_idx_d;
  logic [ID_W-1:0]       found_id_q, found_id_d;

  // pending result
  status_e              res_status_q, res_status_d;
  logic                 res_hit_q, res_hit_d;
  logic [TRK_OUT_W-1:0] res_trk_q, res_trk_d;
  logic [IDX_OUT_W-1:0] res_idx_q, res_idx_d;
  logic [ID_W-1:0]      res_id_q, res_id_d;
  logic [CNT_OUT_W-1:0] res_cnt_q, res_cnt_d;

  // output register
  logic                 out_valid_q, out_valid_d;
  logic                 out_load;
  status_e              out_status_q;
  logic                 out_hit_q;
  logic [TRK_OUT_W-1:0] out_trk_q;
  logic [IDX_OUT_W-1:0] out_idx_q;
  logic [ID_W-1:0]      out_id_q;
  logic [CNT_OUT_W-1:0] out_cnt_q;

  // table ports
  logic                       mem_we;
  logic [DW-1:0]              mem_wdata, mem_rdata;
  logic [ID_W-1:0]            r_id;
  logic signed [POS_BITS-1:0] r_start, r_end;
  logic [TW-1:0]              r_trk;
  logic                       cmp_match;

  // free track search
  logic [MAX_TRACKS-1:0] free_vec, low_free;
  logic [TW-1:0]         free_trk;
  logic [CW-1:0]         new_used;
  logic                  issue;

  //--------------------------------------------------------------------------
  // Register port
  //--------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEQ_LEN) ? APB_DW'(seq_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= LEN_W'(1);
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SEQ_LEN)) begin
      seq_len_q <= pwdata[LEN_W-1:0];
    end
  end

  //--------------------------------------------------------------------------
  // Table and compare unit
  //--------------------------------------------------------------------------
  assign mem_wdata = {id_q, start_q, end_q, free_trk};

  itv_store #(
    .DEPTH (MAX_ENTRIES),
    .AW    (IW),
    .DW    (DW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (count_q[IW-1:0]),
    .wdata_i (mem_wdata),
    .raddr_i (rd_idx_q[IW-1:0]),
    .rdata_o (mem_rdata)
  );

  assign r_trk   = mem_rdata[TW-1:0];
  assign r_end   = mem_rdata[TW +: POS_BITS];
  assign r_start = mem_rdata[TW + POS_BITS +: POS_BITS];
  assign r_id    = mem_rdata[TW + 2 * POS_BITS +: ID_W];

  itv_cmp #(
    .POS_BITS (POS_BITS),
    .TW       (TW)
  ) u_cmp (
    .is_add_i    (action_q == ACT_ADD),
    .ent_start_i (r_start),
    .ent_end_i   (r_end),
    .ent_trk_i   (r_trk),
    .new_start_i (start_q),
    .new_end_i   (end_q),
    .qpos_i      (qpos_q),
    .qtrk_i      (qtrk_q),
    .seq_len_i   (seq_len_q),
    .match_o     (cmp_match)
  );

  //--------------------------------------------------------------------------
  // Lowest free track: isolate the lowest clear bit of the busy map
  //--------------------------------------------------------------------------
  assign free_vec = ~busy_q;
  assign low_free = free_vec & (~free_vec + MAX_TRACKS'(1));

  always_comb begin
    free_trk = '0;
    for (int k = 0; k < MAX_TRACKS; k++) begin
      if (low_free[k]) begin
        free_trk = free_trk | TW'(k);
      end
    end
  end

  assign new_used = CW'(free_trk) + CW'(1);

  //--------------------------------------------------------------------------
  // Sequencer
  //--------------------------------------------------------------------------
  assign in_ready_o = (state_q == ST_IDLE);
  assign issue      = (rd_idx_q != count_q);
  assign out_load   = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    used_d       = used_q;
    rd_idx_d     = rd_idx_q;
    pend_d       = 1'b0;
    cmp_idx_d    = cmp_idx_q;
    busy_d       = busy_q;
    found_d      = found_q;
    found_idx_d  = found_idx_q;
    found_id_d   = found_id_q;
    res_status_d = res_status_q;
    res_hit_d    = res_hit_q;
    res_trk_d    = res_trk_q;
    res_idx_d    = res_idx_q;
    res_id_d     = res_id_q;
    res_cnt_d    = res_cnt_q;
    mem_we       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_status_d = STATUS_OK;
          res_hit_d    = 1'b0;
          res_trk_d    = '0;
          res_idx_d    = '0;
          res_id_d     = '0;
          res_cnt_d    = CNT_OUT_W'(used_q);
          rd_idx_d     = '0;
          busy_d       = '0;
          found_d      = 1'b0;
          case (action_e'(action_i))
            ACT_ADD: begin
              if (count_q == (IW + 1)'(MAX_ENTRIES)) begin
                res_status_d = STATUS_FULL;
                state_d      = ST_EMIT;
              end else begin
                state_d = ST_SCAN;
              end
            end
            ACT_QUERY: begin
              state_d = ST_SCAN;
            end
            ACT_CLEAR: begin
              count_d   = '0;
              used_d    = '0;
              res_cnt_d = '0;
              state_d   = ST_EMIT;
            end
            default: begin
              state_d = ST_EMIT;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // issue one read per cycle, compare the word read the cycle before
        if (issue) begin
          rd_idx_d  = rd_idx_q + (IW + 1)'(1);
          pend_d    = 1'b1;
          cmp_idx_d = rd_idx_q[IW-1:0];
        end
        if (pend_q && cmp_match) begin
          busy_d = busy_q | (MAX_TRACKS'(1) << r_trk);
          if (!found_q) begin
            found_d     = 1'b1;
            found_idx_d = cmp_idx_q;
            found_id_d  = r_id;
          end
        end
        if (!issue && !pend_q) begin
          if (action_q == ACT_ADD) begin
            state_d = ST_FIND;
          end else begin
            res_hit_d = found_q;
            res_trk_d = qtrk_q;
            res_idx_d = found_q ? IDX_OUT_W'(found_idx_q) : '0;
            res_id_d  = found_q ? found_id_q : '0;
            state_d   = ST_EMIT;
          end
        end
      end

      ST_FIND: begin
        // take the lowest free track and append the entry, or report no track if none is free
        if (low_free == '0) begin
          res_status_d = STATUS_NO_TRACK;
        end else begin
          mem_we    = 1'b1;
          count_d   = count_q + (IW + 1)'(1);
          used_d    = (new_used > used_q) ? new_used : used_q;
          res_hit_d = 1'b1;
          res_trk_d = TRK_OUT_W'(free_trk);
          res_idx_d = IDX_OUT_W'(count_q[IW-1:0]);
          res_id_d  = id_q;
          res_cnt_d = CNT_OUT_W'(used_d);
        end
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      used_q      <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      busy_q      <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      used_q      <= used_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      busy_q      <= busy_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and result registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      action_q <= action_e'(action_i);
      id_q     <= entry_id_i;
      start_q  <= start_pos_i;
      end_q    <= end_pos_i;
      qpos_q   <= query_pos_i;
      qtrk_q   <= query_track_i;
    end
    cmp_idx_q    <= cmp_idx_d;
    found_idx_q  <= found_idx_d;
    found_id_q   <= found_id_d;
    res_status_q <= res_status_d;
    res_hit_q    <= res_hit_d;
    res_trk_q    <= res_trk_d;
    res_idx_q    <= res_idx_d;
    res_id_q     <= res_id_d;
    res_cnt_q    <= res_cnt_d;
  end

  //--------------------------------------------------------------------------
  // Output register: hold the result until the transaction completes
  //--------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status_q;
      out_hit_q    <= res_hit_q;
      out_trk_q    <= res_trk_q;
      out_idx_q    <= res_idx_q;
      out_id_q     <= res_id_q;
      out_cnt_q    <= res_cnt_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign hit_o         = out_hit_q;
  assign track_o       = out_trk_q;
  assign entry_index_o = out_idx_q;
  assign found_id_o    = out_id_q;
  assign track_count_o = out_cnt_q;

endmodule

// ===== hw/rtl/itv_checker.sv =====
// Port-level checks for the interval track assigner, bound to its top level.
// Depends on itv_pkg for the status codes.
module itv_checker #(
  parameter int unsigned MAX_TRACKS = 32
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic [1:0]                          status_o,
  input logic                                hit_o,
  input logic [itv_pkg::TRK_OUT_W-1:0]       track_o,
  input logic [itv_pkg::IDX_OUT_W-1:0]       entry_index_o,
  input logic [itv_pkg::ID_W-1:0]            found_id_o,
  input logic [itv_pkg::CNT_OUT_W-1:0]       track_count_o
);
  import itv_pkg::*;

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(hit_o)
      && $stable(track_o) && $stable(entry_index_o) && $stable(found_id_o)
      && $stable(track_count_o))
    else $error("result changed while stalled");

  // Drop ready once a transaction is taken: one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input still ready after accept");

  // A hit never comes with an error status
  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && hit_o |-> status_o == STATUS_OK)
    else $error("hit with error status");

  // Failed adds carry zero track, index and id
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_FULL || status_o == STATUS_NO_TRACK)
      |-> track_o == '0 && entry_index_o == '0 && found_id_o == '0 && !hit_o)
    else $error("failed add with nonzero fields");

  // Track count stays within the number of tracks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(track_count_o) <= MAX_TRACKS)
    else $error("track count out of range");

endmodule

bind interval_track_assigner itv_checker #(.MAX_TRACKS(MAX_TRACKS)) u_itv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .status_o      (status_o),
  .hit_o         (hit_o),
  .track_o       (track_o),
  .entry_index_o (entry_index_o),
  .found_id_o    (found_id_o),
  .track_count_o (track_count_o)
);

// ===== bench/interval_track_assigner_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for interval_track_assigner: adds, queries and clears
// against a shadow track table. Depends on itv_pkg and the block's RTL only.
module interval_track_assigner_test;
  import itv_pkg::*;

  localparam int unsigned MAX_ENTRIES = 256;
  localparam int unsigned MAX_TRACKS  = 32;
  localparam int unsigned POS_BITS    = 25;

  localparam longint POS_MAX = (longint'(1) << (POS_BITS - 1)) - 1;
  localparam longint POS_MIN = -POS_MAX - 1;
  localparam logic [QPOS_W-1:0] QPOS_MAX = '1;
  localparam logic [1:0] ACT_UNDEFINED = 2'd3;
  localparam logic [APB_AW-1:0] SEQ_LEN_ADDR = {REG_SEQ_LEN, 2'b00};
  localparam int unsigned MAX_GAP = 20;

  typedef struct {
    logic [1:0]                 action;
    logic [ID_W-1:0]            entry_id;
    logic signed [POS_BITS-1:0] start_pos;
    logic signed [POS_BITS-1:0] end_pos;
    logic [QPOS_W-1:0]          query_pos;
    logic [QTRK_W-1:0]          query_track;
  } track_request_t;

  typedef struct {
    status_e               status;
    logic                  hit;
    logic [TRK_OUT_W-1:0]  track;
    logic [IDX_OUT_W-1:0]  entry_index;
    logic [ID_W-1:0]       found_id;
    logic [CNT_OUT_W-1:0]  track_count;
  } track_reply_t;

  // DUT ports
  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [APB_AW-1:0]          paddr = '0;
  logic [APB_DW-1:0]          pwdata = '0;
  logic [APB_DW-1:0]          prdata;
  logic                       pready;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [1:0]                 action_i = '0;
  logic [ID_W-1:0]            entry_id_i = '0;
  logic signed [POS_BITS-1:0] start_pos_i = '0;
  logic signed [POS_BITS-1:0] end_pos_i = '0;
  logic [QPOS_W-1:0]          query_pos_i = '0;
  logic [QTRK_W-1:0]          query_track_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [1:0]                 status_o;
  logic                       hit_o;
  logic [TRK_OUT_W-1:0]       track_o;
  logic [IDX_OUT_W-1:0]       entry_index_o;
  logic [ID_W-1:0]            found_id_o;
  logic [CNT_OUT_W-1:0]       track_count_o;

  // Shadow copy of the block's table and register
  logic [LEN_W-1:0]           seq_length = 1;
  logic [ID_W-1:0]            tbl_id    [MAX_ENTRIES];
  logic signed [POS_BITS-1:0] tbl_start [MAX_ENTRIES];
  logic signed [POS_BITS-1:0] tbl_end   [MAX_ENTRIES];
  int unsigned                tbl_track [MAX_ENTRIES];
  int unsigned                tbl_count = 0;
  int unsigned                tracks_in_use = 0;

  track_reply_t pending_replies[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_off_cycles = 0;
  int n_mismatch = 0;
  int n_adds = 0, n_full = 0, n_no_track = 0;
  int n_queries = 0, n_query_hits = 0, n_clears = 0, n_undefined = 0;

  interval_track_assigner #(
    .MAX_ENTRIES(MAX_ENTRIES),
    .MAX_TRACKS (MAX_TRACKS),
    .POS_BITS   (POS_BITS)
  ) dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Wrap-around coverage test of one stored interval
  function automatic bit interval_covers(int unsigned idx, longint p);
    longint s, e, len;
    s = tbl_start[idx];
    e = tbl_end[idx];
    len = longint'(seq_length);
    if (p >= s && p <= e) return 1'b1;
    if (e < s) return p >= s || p <= e;
    if (e >= len) return p >= s || p <= e - len;
    return 1'b0;
  endfunction

  // Apply one accepted transaction to the shadow table and return its reply
  function automatic track_reply_t predict_reply(track_request_t rq);
    track_reply_t rp;
    logic [63:0]  busy;
    int unsigned  t;
    longint       s, e;
    bit           found;
    rp.status = STATUS_OK;
    rp.hit = 1'b0;
    rp.track = '0;
    rp.entry_index = '0;
    rp.found_id = '0;
    rp.track_count = CNT_OUT_W'(tracks_in_use);
    case (rq.action)
      ACT_ADD: begin
        n_adds++;
        s = rq.start_pos;
        e = rq.end_pos;
        if (tbl_count >= MAX_ENTRIES) begin
          rp.status = STATUS_FULL;
          n_full++;
        end else begin
          busy = '0;
          for (int i = 0; i < tbl_count; i++) begin
            if (tbl_start[i] <= e && tbl_end[i] >= s) busy[tbl_track[i]] = 1'b1;
          end
          t = 0;
          while (t < 64 && busy[t]) t++;
          if (t >= MAX_TRACKS) begin
            rp.status = STATUS_NO_TRACK;
            n_no_track++;
          end else begin
            tbl_id[tbl_count] = rq.entry_id;
            tbl_start[tbl_count] = rq.start_pos;
            tbl_end[tbl_count] = rq.end_pos;
            tbl_track[tbl_count] = t;
            rp.hit = 1'b1;
            rp.track = TRK_OUT_W'(t);
            rp.entry_index = IDX_OUT_W'(tbl_count);
            rp.found_id = rq.entry_id;
            tbl_count++;
            if (t + 1 > tracks_in_use) tracks_in_use = t + 1;
            rp.track_count = CNT_OUT_W'(tracks_in_use);
          end
        end
      end
      ACT_QUERY: begin
        n_queries++;
        rp.track = rq.query_track;
        found = 1'b0;
        for (int i = 0; i < tbl_count && !found; i++) begin
          if (tbl_track[i] == rq.query_track && interval_covers(i, rq.query_pos)) begin
            found = 1'b1;
            rp.hit = 1'b1;
            rp.entry_index = IDX_OUT_W'(i);
            rp.found_id = tbl_id[i];
          end
        end
        if (found) n_query_hits++;
      end
      ACT_CLEAR: begin
        n_clears++;
        tbl_count = 0;
        tracks_in_use = 0;
        rp.track_count = '0;
      end
      default: n_undefined++;
    endcase
    return rp;
  endfunction

  function automatic logic signed [POS_BITS-1:0] clamp_pos(longint v);
    if (v > POS_MAX) return POS_BITS'(POS_MAX);
    if (v < POS_MIN) return POS_BITS'(POS_MIN);
    return POS_BITS'(v);
  endfunction

  function automatic logic [QPOS_W-1:0] clamp_qpos(longint v);
    if (v < 0) return '0;
    if (v > longint'(QPOS_MAX)) return QPOS_MAX;
    return QPOS_W'(v);
  endfunction

  function automatic track_request_t make_add(logic [ID_W-1:0] id, longint s, longint e);
    track_request_t rq;
    rq = '{ACT_ADD, id, clamp_pos(s), clamp_pos(e), '0, '0};
    return rq;
  endfunction

  function automatic track_request_t make_query(longint p, int unsigned trk);
    track_request_t rq;
    rq = '{ACT_QUERY, '0, '0, '0, clamp_qpos(p), QTRK_W'(trk)};
    return rq;
  endfunction

  function automatic track_request_t make_plain(logic [1:0] act);
    track_request_t rq;
    rq = '{act, '0, '0, '0, '0, '0};
    return rq;
  endfunction

  // Positions near the start of the sequence and, for long ones, near its end
  function automatic longint random_position(int unsigned span);
    if (seq_length <= 4096) return longint'($urandom_range(span + 15)) - 8;
    if ($urandom_range(1)) return longint'($urandom_range(4095)) - 16;
    return longint'(seq_length) - longint'($urandom_range(4095));
  endfunction

  // Mostly well-formed adds and queries aimed at stored intervals, some noise
  function automatic track_request_t random_request();
    track_request_t rq;
    int unsigned    r, span, j;
    longint         s, e, p;
    rq.action = ACT_ADD;
    rq.entry_id = ID_W'($urandom);
    rq.start_pos = POS_BITS'($urandom);
    rq.end_pos = POS_BITS'($urandom);
    rq.query_pos = QPOS_W'($urandom);
    rq.query_track = QTRK_W'($urandom);
    span = (seq_length < 64) ? 64 : ((seq_length > 4096) ? 4096 : 32'(seq_length));
    r = $urandom_range(99);
    if (r < 48) begin
      s = random_position(span);
      case ($urandom_range(9))
        0, 1: begin
          s = longint'(seq_length) - longint'($urandom_range(span / 4));
          e = $urandom_range(span / 4);
        end
        2: begin
          s = longint'(seq_length) - longint'($urandom_range(span / 8));
          e = s + longint'($urandom_range(span / 2));
        end
        3: e = s;
        default: e = s + longint'($urandom_range(span / 4));
      endcase
      rq.start_pos = clamp_pos(s);
      rq.end_pos = clamp_pos(e);
    end else if (r < 88) begin
      rq.action = ACT_QUERY;
      if (tbl_count != 0 && $urandom_range(9) < 7) begin
        j = $urandom_range(tbl_count - 1);
        s = tbl_start[j];
        e = tbl_end[j];
        case ($urandom_range(5))
          0: p = s;
          1: p = e;
          2: p = e - longint'(seq_length);
          3: p = s - 1;
          4: p = e + 1;
          default: p = s + (e - s) / 2;
        endcase
        rq.query_track = QTRK_W'(tbl_track[j]);
      end else begin
        p = random_position(span);
      end
      rq.query_pos = clamp_qpos(p);
    end else if (r < 90) begin
      rq.action = ACT_CLEAR;
    end else if (r < 92) begin
      rq.action = ACT_UNDEFINED;
    end else begin
      rq.action = $urandom_range(1) ? ACT_ADD : ACT_QUERY;
    end
    return rq;
  endfunction

  // Offer one transaction, optionally after an idle gap, and record its reply
  task automatic send_request(track_request_t rq);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= rq.action;
    entry_id_i    <= rq.entry_id;
    start_pos_i   <= rq.start_pos;
    end_pos_i     <= rq.end_pos;
    query_pos_i   <= rq.query_pos;
    query_track_i <= rq.query_track;
    do @(posedge clk_i); while (!in_ready_o);
    pending_replies.insert(pending_replies.size(), predict_reply(rq));
  endtask

  // Stop offering and hold until every pending reply has come back
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_sequence_length(logic [LEN_W-1:0] len);
    drain_replies();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEQ_LEN_ADDR;
    pwdata  <= APB_DW'(len);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    seq_length = len;
  endtask

  // Drive the result ready: long hold-offs first, else random stalls
  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_off_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each accepted result with the oldest pending reply
  always @(posedge clk_i) begin : reply_checker
    track_reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_replies.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("result with no pending reply at %0t", $realtime);
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status || hit_o !== want.hit || track_o !== want.track ||
            entry_index_o !== want.entry_index || found_id_o !== want.found_id ||
            track_count_o !== want.track_count) begin
          n_mismatch++;
          if (n_mismatch <= 10) begin
            $display("mismatch at %0t: expected st=%0d hit=%0d trk=%0d idx=%0d id=%h cnt=%0d",
                     $realtime, want.status, want.hit, want.track, want.entry_index,
                     want.found_id, want.track_count);
            $display("  actual st=%0d hit=%0d trk=%0d idx=%0d id=%h cnt=%0d",
                     status_o, hit_o, track_o, entry_index_o, found_id_o, track_count_o);
          end
        end
      end
    end
  end

  // Field extremes, each action and the wrap rules at several lengths
  task automatic test_directed_cases();
    // reset length of one: nearly every interval runs past the end
    send_request(make_query(0, 0));
    send_request(make_add(16'hFFFF, POS_MIN, POS_MAX));
    send_request(make_add(16'h0000, 10, 20));
    send_request(make_query(23, 1));
    send_request(make_plain(ACT_UNDEFINED));
    send_request(make_plain(ACT_CLEAR));
    write_sequence_length(24'd100);
    send_request(make_add(16'h8001, 10, 20));
    send_request(make_add(16'h0002, 30, 40));
    send_request(make_add(16'h0003, 90, 5));
    send_request(make_add(16'h0004, 95, 110));
    send_request(make_add(16'h0005, 15, 35));
    send_request(make_add(16'h0006, POS_MIN, POS_MAX));
    // plain hit, both halves of a wrapped interval, the part past the end
    send_request(make_query(15, 0));
    send_request(make_query(97, 0));
    send_request(make_query(2, 0));
    send_request(make_query(8, 0));
    send_request(make_query(50, 0));
    send_request(make_query(QPOS_MAX, 2));
    send_request(make_query(0, 31));
    send_request(make_query(20, 1));
    // zero length: any interval reaching past zero wraps
    write_sequence_length(24'd0);
    send_request(make_query(1000, 0));
    write_sequence_length(24'hFFFFFF);
    send_request(make_add(16'h0007, 16777200, POS_MAX));
    send_request(make_query(0, 0));
    send_request(make_plain(ACT_CLEAR));
    send_request(make_query(5, 0));
    drain_replies();
  endtask

  // Stack intervals until every track is taken, then overflow
  task automatic test_track_exhaustion();
    send_request(make_plain(ACT_CLEAR));
    for (int k = 0; k < MAX_TRACKS; k++) send_request(make_add(ID_W'(k), 0, 10));
    send_request(make_add(16'hBEEF, 5, 5));
    send_request(make_query(5, MAX_TRACKS - 1));
    send_request(make_add(16'h1234, 20, 30));
    drain_replies();
  endtask

  // Hold the result side off while requests keep coming, then drain
  task automatic test_output_backpressure();
    int saved_tx;
    saved_tx = tx_idle_pct;
    tx_idle_pct = 0;
    hold_off_cycles = 400;
    for (int k = 0; k < 8; k++) send_request(make_query(longint'(k), k));
    drain_replies();
    tx_idle_pct = saved_tx;
  endtask

  // Fill every entry, add one more, and find the last entry
  task automatic test_table_full();
    send_request(make_plain(ACT_CLEAR));
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      send_request(make_add(ID_W'(k), longint'(2 * k), longint'(2 * k)));
    end
    send_request(make_add(16'hFFFF, 0, 0));
    send_request(make_query(2 * (MAX_ENTRIES - 1), 0));
    send_request(make_plain(ACT_CLEAR));
    drain_replies();
  endtask

  task automatic test_random_traffic(int tx_pct, int rx_pct, logic [LEN_W-1:0] len,
                                     int count);
    track_request_t rq;
    write_sequence_length(len);
    for (int k = 0; k < count; k++) begin
      // quiet stretch with no idling on either side
      if (k % 200 >= 160) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
      end
      if (k == count / 2) drain_replies();
      rq = random_request();
      send_request(rq);
    end
    drain_replies();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 12;
    rx_idle_pct = 57;
    test_directed_cases();
    test_track_exhaustion();
    test_output_backpressure();
    test_table_full();
    test_random_traffic(12, 57, 24'hFFFFFF, 460);
    test_random_traffic(57, 12, LEN_W'($urandom_range(16, 4096)), 460);
    test_random_traffic(0, 0, 24'd1, 450);
    repeat (MAX_ENTRIES + 8) @(posedge clk_i);
    $display("Covered %0d adds (%0d on a full table, %0d with no free track), %0d queries",
             n_adds, n_full, n_no_track, n_queries);
    $display("(%0d hits), %0d clears and %0d undefined actions over several lengths.",
             n_query_hits, n_clears, n_undefined);
    if (n_mismatch == 0 && pending_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #80_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
